// File: rtl/ebfx_pkg.sv
// ebfx_pkg: types, codes and single-precision helper functions for the
// error-bounded float xor encoder. Depends on nothing; used by every rtl file.
`default_nettype none

package ebfx_pkg;

  localparam logic [31:0] FP_ONE     = 32'h3F80_0000;
  localparam logic [31:0] FP_NEG_ONE = 32'hBF80_0000;
  localparam logic [31:0] FP_QNAN    = 32'h7FC0_0000;
  localparam logic [31:0] FP_INF     = 32'h7F80_0000;

  // configuration register indexes
  localparam logic REG_ERROR_MODE  = 1'b0;
  localparam logic REG_ERROR_LIMIT = 1'b1;

  // adder operand selections
  localparam logic [2:0] ADD_X_PREV = 3'd0;
  localparam logic [2:0] ADD_X_LO   = 3'd1;
  localparam logic [2:0] ADD_X_HI   = 3'd2;
  localparam logic [2:0] ADD_X_MID  = 3'd3;
  localparam logic [2:0] ADD_FLOOR  = 3'd4;
  localparam logic [2:0] ADD_LO_ONE = 3'd5;
  localparam logic [2:0] ADD_LO_HI  = 3'd6;

  // result selections
  localparam logic [2:0] OUT_PREV = 3'd0;
  localparam logic [2:0] OUT_LO   = 3'd1;
  localparam logic [2:0] OUT_HI   = 3'd2;
  localparam logic [2:0] OUT_MID  = 3'd3;
  localparam logic [2:0] OUT_RAW  = 3'd4;

  typedef struct packed {
    logic        special;
    logic [31:0] spec;
    logic        sign;
    logic        sub;
    logic [7:0]  exp;
    logic [27:0] sum;
  } add_mid_t;

  typedef struct packed {
    logic               special;
    logic [31:0]        spec;
    logic               sign;
    logic signed [10:0] exp;
    logic [47:0]        prod;
  } mul_mid_t;

  typedef struct packed {
    logic       load;
    logic       add_go;
    logic [2:0] add_sel;
    logic       mul_go;
    logic       bound_mul;
    logic       lo_floor;
    logic       lo_res;
    logic       hi_res;
    logic       mid_res;
    logic       lo_mid;
    logic       hi_mid;
    logic       out_load;
    logic [2:0] out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic in_bound;
    logic x_lt_mid;
    logic floor_adj;
    logic first;
    logic mode;
  } dp_status_t;

  function automatic logic is_nan(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
  endfunction

  function automatic logic [31:0] order_key(logic [31:0] a);
    return a[31] ? ~a : {1'b1, a[30:0]};
  endfunction

  function automatic logic fp_le(logic [31:0] a, logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return 1'b1;
    return order_key(a) <= order_key(b);
  endfunction

  function automatic logic fp_lt(logic [31:0] a, logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return 1'b0;
    return order_key(a) < order_key(b);
  endfunction

  // exact divide by two, round to nearest even when it underflows
  function automatic logic [31:0] fp_halve(logic [31:0] a);
    logic [23:0] sig;
    logic [23:0] r;
    logic        up;
    if (a[30:23] == 8'hFF) return a;
    if (a[30:23] >= 8'd2) return {a[31], a[30:23] - 8'd1, a[22:0]};
    sig = {a[23], a[22:0]};
    up  = sig[0] & sig[1];
    r   = {1'b0, sig[23:1]} + 24'(up);
    return {a[31], 7'd0, r};
  endfunction

  function automatic logic [4:0] lzc27(logic [26:0] v);
    logic [4:0] lz;
    lz = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) lz = 5'(26 - i);
    end
    return lz;
  endfunction

  function automatic logic [5:0] lzc48(logic [47:0] v);
    logic [5:0] lz;
    lz = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) lz = 6'(47 - i);
    end
    return lz;
  endfunction

  // n: hidden bit at 26, guard/round/sticky at [2:0]; e >= 1, n[26] low only when e is 1
  function automatic logic [31:0] round_pack(logic s, logic [9:0] e, logic [26:0] n);
    logic [7:0]  ef;
    logic        up;
    logic [31:0] v;
    if (e >= 10'd255) return {s, FP_INF[30:0]};
    ef = n[26] ? e[7:0] : 8'd0;
    up = n[2] & (n[1] | n[0] | n[3]);
    v  = {1'b0, ef, n[25:3]} + 32'(up);
    return {s, v[30:0]};
  endfunction

  function automatic add_mid_t fp_add_align(logic [31:0] a, logic [31:0] b);
    add_mid_t    r;
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  eb;
    logic [7:0]  es;
    logic [23:0] mb;
    logic [23:0] ms;
    logic [7:0]  d;
    logic [4:0]  dc;
    logic [50:0] tmp;
    logic [26:0] msx;
    r.special = 1'b0;
    r.spec    = 32'd0;
    if (is_nan(a) || is_nan(b)) begin
      r.special = 1'b1;
      r.spec    = FP_QNAN;
    end else if (is_inf(a) && is_inf(b) && (a[31] != b[31])) begin
      r.special = 1'b1;
      r.spec    = FP_QNAN;
    end else if (is_inf(a)) begin
      r.special = 1'b1;
      r.spec    = a;
    end else if (is_inf(b)) begin
      r.special = 1'b1;
      r.spec    = b;
    end
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    eb  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    mb  = {big[30:23] != 8'd0, big[22:0]};
    ms  = {sml[30:23] != 8'd0, sml[22:0]};
    d   = eb - es;
    dc  = (d > 8'd27) ? 5'd27 : d[4:0];
    tmp = {ms, 27'd0} >> dc;
    msx = {tmp[50:25], tmp[24] | (|tmp[23:0])};
    r.sign = big[31];
    r.sub  = big[31] != sml[31];
    r.exp  = eb;
    if (r.sub) r.sum = {1'b0, mb, 3'd0} - {1'b0, msx};
    else       r.sum = {1'b0, mb, 3'd0} + {1'b0, msx};
    return r;
  endfunction

  function automatic logic [31:0] fp_add_norm(add_mid_t m);
    logic [4:0]  lz;
    logic [7:0]  lim;
    logic [7:0]  sh;
    logic [26:0] n;
    logic [9:0]  e;
    if (m.special) return m.spec;
    if (m.sum == 28'd0) return {m.sign & ~m.sub, 31'd0};
    if (m.sum[27]) begin
      n = {m.sum[27:2], m.sum[1] | m.sum[0]};
      e = {2'b0, m.exp} + 10'd1;
    end else begin
      lz  = lzc27(m.sum[26:0]);
      lim = m.exp - 8'd1;
      sh  = ({3'b0, lz} < lim) ? {3'b0, lz} : lim;
      n   = m.sum[26:0] << sh[4:0];
      e   = {2'b0, m.exp} - {2'b0, sh};
    end
    return round_pack(m.sign, e, n);
  endfunction

  function automatic mul_mid_t fp_mul_pre(logic [31:0] a, logic [31:0] b);
    mul_mid_t r;
    logic     az;
    logic     bz;
    logic     s;
    az = a[30:0] == 31'd0;
    bz = b[30:0] == 31'd0;
    s  = a[31] ^ b[31];
    r.special = 1'b0;
    r.spec    = 32'd0;
    if (is_nan(a) || is_nan(b) || (is_inf(a) && bz) || (is_inf(b) && az)) begin
      r.special = 1'b1;
      r.spec    = FP_QNAN;
    end else if (is_inf(a) || is_inf(b)) begin
      r.special = 1'b1;
      r.spec    = {s, FP_INF[30:0]};
    end else if (az || bz) begin
      r.special = 1'b1;
      r.spec    = {s, 31'd0};
    end
    r.sign = s;
    r.exp  = $signed({3'b0, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]})
           + $signed({3'b0, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]}) - 11'sd127;
    r.prod = {24'd0, a[30:23] != 8'd0, a[22:0]} * {24'd0, b[30:23] != 8'd0, b[22:0]};
    return r;
  endfunction

  function automatic logic [31:0] fp_mul_norm(mul_mid_t m);
    logic [5:0]         lz;
    logic signed [11:0] ep;
    logic signed [11:0] rs;
    logic signed [11:0] amt;
    logic signed [11:0] neg;
    logic [5:0]         rsh;
    logic [95:0]        t;
    logic [47:0]        q;
    logic               st;
    logic [9:0]         ef;
    logic [26:0]        n;
    if (m.special) return m.spec;
    lz  = lzc48(m.prod);
    ep  = $signed({m.exp[10], m.exp}) + 12'sd1 - $signed({6'd0, lz});
    st  = 1'b0;
    q   = m.prod;
    rs  = 12'sd0;
    amt = 12'sd0;
    neg = 12'sd0;
    rsh = 6'd0;
    t   = 96'd0;
    if (ep >= 12'sd1) begin
      ef = (ep >= 12'sd255) ? 10'd255 : ep[9:0];
      q  = m.prod << lz;
    end else begin
      ef  = 10'd1;
      rs  = 12'sd1 - ep;
      amt = $signed({6'd0, lz}) - rs;
      if (amt >= 12'sd0) begin
        q = m.prod << amt[5:0];
      end else begin
        neg = -amt;
        rsh = (neg > 12'sd49) ? 6'd49 : neg[5:0];
        t   = {m.prod, 48'd0} >> rsh;
        q   = t[95:48];
        st  = |t[47:0];
      end
    end
    n = {q[47:22], q[21] | (|q[20:0]) | st};
    return round_pack(m.sign, ef, n);
  endfunction

endpackage

`default_nettype wire

// File: rtl/ebfx_datapath.sv
// ebfx_datapath: configuration registers, sample registers, two-stage float
// adder, two-stage multiplier and result register. Depends on ebfx_pkg.
`default_nettype none

module ebfx_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire logic [31:0]         value_bits,
  input  wire logic                first_of_block,
  input  wire ebfx_pkg::dp_cmd_t   cmd,
  output ebfx_pkg::dp_status_t     status,
  output logic [31:0]              xor_bits,
  output logic [31:0]              approx_bits,
  output logic                     search_exhausted
);

  logic                 error_mode;
  logic [31:0]          error_limit;
  logic [31:0]          x;
  logic                 first;
  logic [31:0]          bound;
  logic [31:0]          prev;
  logic [31:0]          lo;
  logic [31:0]          hi;
  logic [31:0]          mid;
  logic [31:0]          res;
  ebfx_pkg::add_mid_t   am;
  ebfx_pkg::mul_mid_t   mm;
  logic [31:0]          op_a;
  logic [31:0]          op_b;
  logic [31:0]          ft;
  logic                 fadj;
  logic [31:0]          fmask;
  logic [31:0]          approx;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_mode  <= 1'b0;
      error_limit <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ebfx_pkg::REG_ERROR_MODE:  error_mode  <= cfg_data[0];
        ebfx_pkg::REG_ERROR_LIMIT: error_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // floor: truncate fraction; negative non-integers |x|>=1 need a -1 add
  always_comb begin
    ft    = x;
    fadj  = 1'b0;
    fmask = 32'd0;
    if (x[30:23] >= 8'd150) begin
      ft = x;
    end else if (x[30:23] < 8'd127) begin
      if (x[30:0] == 31'd0) ft = x;
      else ft = x[31] ? ebfx_pkg::FP_NEG_ONE : 32'd0;
    end else begin
      fmask = (32'd1 << (8'd150 - x[30:23])) - 32'd1;
      if ((x & fmask) != 32'd0) begin
        ft   = x & ~fmask;
        fadj = x[31];
      end
    end
  end

  always_comb begin
    op_a = x;
    op_b = {~prev[31], prev[30:0]};
    case (cmd.add_sel)
      ebfx_pkg::ADD_X_PREV: op_b = {~prev[31], prev[30:0]};
      ebfx_pkg::ADD_X_LO:   op_b = {~lo[31], lo[30:0]};
      ebfx_pkg::ADD_X_HI:   op_b = {~hi[31], hi[30:0]};
      ebfx_pkg::ADD_X_MID:  op_b = {~mid[31], mid[30:0]};
      ebfx_pkg::ADD_FLOOR: begin
        op_a = ft;
        op_b = ebfx_pkg::FP_NEG_ONE;
      end
      ebfx_pkg::ADD_LO_ONE: begin
        op_a = lo;
        op_b = ebfx_pkg::FP_ONE;
      end
      ebfx_pkg::ADD_LO_HI: begin
        op_a = lo;
        op_b = hi;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.add_go) am <= ebfx_pkg::fp_add_align(op_a, op_b);
    res <= ebfx_pkg::fp_add_norm(am);
    if (cmd.mul_go) mm <= ebfx_pkg::fp_mul_pre(error_limit, {1'b0, x[30:0]});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x     <= value_bits;
      first <= first_of_block;
      bound <= error_limit;
    end
    if (cmd.bound_mul) bound <= ebfx_pkg::fp_mul_norm(mm);
    if (cmd.lo_floor)  lo <= ft;
    if (cmd.lo_res)    lo <= res;
    if (cmd.lo_mid)    lo <= mid;
    if (cmd.hi_res)    hi <= res;
    if (cmd.hi_mid)    hi <= mid;
    if (cmd.mid_res)   mid <= ebfx_pkg::fp_halve(res);
  end

  always_comb begin
    case (cmd.out_sel)
      ebfx_pkg::OUT_PREV: approx = prev;
      ebfx_pkg::OUT_LO:   approx = lo;
      ebfx_pkg::OUT_HI:   approx = hi;
      ebfx_pkg::OUT_MID:  approx = mid;
      default:            approx = x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= 32'd0;
    end else if (cmd.out_load) begin
      prev <= approx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      approx_bits      <= approx;
      xor_bits         <= first ? approx : (approx ^ prev);
      search_exhausted <= cmd.out_sel == ebfx_pkg::OUT_RAW;
    end
  end

  always_comb begin
    status.in_bound  = ebfx_pkg::fp_le({1'b0, res[30:0]}, bound);
    status.x_lt_mid  = ebfx_pkg::fp_lt(x, mid);
    status.floor_adj = fadj;
    status.first     = first;
    status.mode      = error_mode;
  end

endmodule

`default_nettype wire

// File: rtl/ebfx_ctrl.sv
// ebfx_ctrl: state machine that sequences the relative-mode bound multiply, reuse test,
// floor, bisection and result handoff. Depends on ebfx_pkg.
`default_nettype none

module ebfx_ctrl #(
  parameter int MAX_STEPS = 160
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  input  wire ebfx_pkg::dp_status_t status,
  output ebfx_pkg::dp_cmd_t         cmd
);

  localparam int STEP_W = $clog2(MAX_STEPS);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_MUL      = 5'd1;
  localparam logic [4:0] S_MULB     = 5'd2;
  localparam logic [4:0] S_PREV     = 5'd3;
  localparam logic [4:0] S_WAIT     = 5'd4;
  localparam logic [4:0] S_CHKPREV  = 5'd5;
  localparam logic [4:0] S_FLOOR    = 5'd6;
  localparam logic [4:0] S_FLOORSET = 5'd7;
  localparam logic [4:0] S_TLO      = 5'd8;
  localparam logic [4:0] S_CHKLO    = 5'd9;
  localparam logic [4:0] S_HISET    = 5'd10;
  localparam logic [4:0] S_THI      = 5'd11;
  localparam logic [4:0] S_CHKHI    = 5'd12;
  localparam logic [4:0] S_SUM      = 5'd13;
  localparam logic [4:0] S_MIDSET   = 5'd14;
  localparam logic [4:0] S_TMID     = 5'd15;
  localparam logic [4:0] S_CHKMID   = 5'd16;
  localparam logic [4:0] S_DONE     = 5'd17;

  logic [4:0]        state;
  logic [4:0]        state_next;
  logic [4:0]        ret;
  logic [4:0]        ret_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [2:0]        osel;
  logic [2:0]        osel_next;

  // no transaction is taken while reset is held
  assign s_tready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd         = '0;
    cmd.out_sel = osel;
    state_next  = state;
    ret_next    = ret;
    step_next   = step;
    osel_next   = osel;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = status.mode ? S_MUL : S_PREV;
        end
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        state_next = S_MULB;
      end
      S_MULB: begin
        cmd.bound_mul = 1'b1;
        state_next    = S_PREV;
      end
      S_PREV: begin
        if (status.first) begin
          state_next = S_FLOOR;
        end else begin
          cmd.add_go  = 1'b1;
          cmd.add_sel = ebfx_pkg::ADD_X_PREV;
          ret_next    = S_CHKPREV;
          state_next  = S_WAIT;
        end
      end
      S_WAIT: state_next = ret;
      S_CHKPREV: begin
        if (status.in_bound) begin
          osel_next  = ebfx_pkg::OUT_PREV;
          state_next = S_DONE;
        end else begin
          state_next = S_FLOOR;
        end
      end
      S_FLOOR: begin
        if (status.floor_adj) begin
          cmd.add_go  = 1'b1;
          cmd.add_sel = ebfx_pkg::ADD_FLOOR;
          ret_next    = S_FLOORSET;
          state_next  = S_WAIT;
        end else begin
          cmd.lo_floor = 1'b1;
          state_next   = S_TLO;
        end
      end
      S_FLOORSET: begin
        cmd.lo_res = 1'b1;
        state_next = S_TLO;
      end
      S_TLO: begin
        cmd.add_go  = 1'b1;
        cmd.add_sel = ebfx_pkg::ADD_X_LO;
        ret_next    = S_CHKLO;
        state_next  = S_WAIT;
      end
      S_CHKLO: begin
        if (status.in_bound) begin
          osel_next  = ebfx_pkg::OUT_LO;
          state_next = S_DONE;
        end else begin
          cmd.add_go  = 1'b1;
          cmd.add_sel = ebfx_pkg::ADD_LO_ONE;
          ret_next    = S_HISET;
          state_next  = S_WAIT;
        end
      end
      S_HISET: begin
        cmd.hi_res = 1'b1;
        state_next = S_THI;
      end
      S_THI: begin
        cmd.add_go  = 1'b1;
        cmd.add_sel = ebfx_pkg::ADD_X_HI;
        ret_next    = S_CHKHI;
        state_next  = S_WAIT;
      end
      S_CHKHI: begin
        if (status.in_bound) begin
          osel_next  = ebfx_pkg::OUT_HI;
          state_next = S_DONE;
        end else begin
          step_next  = '0;
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.add_go  = 1'b1;
        cmd.add_sel = ebfx_pkg::ADD_LO_HI;
        ret_next    = S_MIDSET;
        state_next  = S_WAIT;
      end
      S_MIDSET: begin
        cmd.mid_res = 1'b1;
        state_next  = S_TMID;
      end
      S_TMID: begin
        cmd.add_go  = 1'b1;
        cmd.add_sel = ebfx_pkg::ADD_X_MID;
        ret_next    = S_CHKMID;
        state_next  = S_WAIT;
      end
      S_CHKMID: begin
        if (status.in_bound) begin
          osel_next  = ebfx_pkg::OUT_MID;
          state_next = S_DONE;
        end else begin
          if (status.x_lt_mid) cmd.hi_mid = 1'b1;
          else                 cmd.lo_mid = 1'b1;
          if (step == STEP_W'(MAX_STEPS - 1)) begin
            osel_next  = ebfx_pkg::OUT_RAW;
            state_next = S_DONE;
          end else begin
            step_next  = step + 1'b1;
            state_next = S_SUM;
          end
        end
      end
      S_DONE: begin
        // hold until the result register is free
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret      <= S_IDLE;
      step     <= '0;
      osel     <= ebfx_pkg::OUT_RAW;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      step  <= step_next;
      osel  <= osel_next;
      if (cmd.out_load)  m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/error_bounded_float_xor_encoder_core.sv
// Usage: samples enter on the s_ stream (tdata = value bits, tuser = first of
// block) and results leave on the m_ stream, one result per sample.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 error mode,
// 1 error limit bits); the user writes only while the block is idle, which the block does not enforce.
// Sequence: a sample ends soonest when the previous value is reused and
// longest when the bisection runs all MAX_STEPS steps; each bisection step
// makes two passes through the shared two-stage float adder, and relative
// mode adds the bound multiply before the reuse test.
// Throughput: one sample at a time; s_tready is high only while idle.
// The result register holds a finished transaction, so the next sample is
// taken while the receiver stalls; a second result waits in the last state
// until the register drains.
// Reset (rst, synchronous): clears the state machine, the previous
// approximation and both configuration registers; no clearing pass.
`default_nettype none

module error_bounded_float_xor_encoder_core #(
  parameter int MAX_STEPS = 160
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] value_bits
  input  wire logic [0:0]  s_tuser,   // [0] first_of_block
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [31:0] xor_bits, [63:32] approx_bits
  output logic [0:0]       m_tuser    // [0] search_exhausted
);

  ebfx_pkg::dp_cmd_t    cmd;
  ebfx_pkg::dp_status_t status;
  logic [31:0]          xor_bits;
  logic [31:0]          approx_bits;
  logic                 search_exhausted;

  ebfx_ctrl #(
    .MAX_STEPS (MAX_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ebfx_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .value_bits       (s_tdata),
    .first_of_block   (s_tuser[0]),
    .cmd              (cmd),
    .status           (status),
    .xor_bits         (xor_bits),
    .approx_bits      (approx_bits),
    .search_exhausted (search_exhausted)
  );

  assign m_tdata = {approx_bits, xor_bits};
  assign m_tuser = search_exhausted;

endmodule

`default_nettype wire
